// ----- hw/rtl/tea_pkg.sv -----
// ----------------------------------------------------------------------------
// tea_pkg: shared types and constants for the enrichment argmax block
// Field widths, register indexes and the front-to-back queue word.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int CountW = 32;
  localparam int TotalW = 40;
  localparam int KeyW   = 20;
  localparam int ValueW = 33;
  localparam int ProdW  = 72;
  localparam int NumW   = 88;
  localparam int RatioW = 32;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [1:0] RegTestTotal    = 2'd0;
  localparam logic [1:0] RegControlTotal = 2'd1;
  localparam logic [1:0] RegNormalize    = 2'd2;

  localparam logic signed [ValueW-1:0] LogFloor = -33'sd2097152;

  // word passed from front to back
  typedef struct packed {
    logic              qual;
    logic              last;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] t;
    logic [CountW-1:0] c;
  } item_t;

endpackage

// ----- hw/rtl/tea_front.sv -----
// ----------------------------------------------------------------------------
// tea_front: input stage
// Accepts count pairs, assigns the index, qualifies them and queues them.
// ----------------------------------------------------------------------------
module tea_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       ready,
  input  logic [tea_pkg::CountW-1:0] test_hits,
  input  logic [tea_pkg::CountW-1:0] control_hits,
  input  logic                       last,
  input  logic                       totals_ok,
  output logic                       q_valid,
  input  logic                       q_pop,
  output tea_pkg::item_t             q_word
);

  tea_pkg::item_t           mem [tea_pkg::QDepth];
  logic [tea_pkg::QPtrW-1:0] wp, rp;
  logic [tea_pkg::QPtrW:0]   cnt;
  logic [tea_pkg::KeyW-1:0]  index_counter;
  logic                      push;

  assign ready   = (cnt != 3'(tea_pkg::QDepth));
  assign push    = valid && ready;
  assign q_valid = (cnt != '0);
  assign q_word  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp].qual <= (test_hits != '0) && (control_hits != '0) && totals_ok;
      mem[wp].last <= last;
      mem[wp].key  <= index_counter;
      mem[wp].t    <= test_hits;
      mem[wp].c    <= control_hits;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      index_counter <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
        index_counter <= last ? '0 : index_counter + 1'b1;
      end
      if (q_pop) rp <= rp + 1'b1;
      cnt <= cnt + (push ? 3'd1 : 3'd0) - (q_pop ? 3'd1 : 3'd0);
    end
  end

endmodule

// ----- hw/rtl/tea_back.sv -----
// ----------------------------------------------------------------------------
// tea_back: divide, compare and report
// Serial restoring divide per qualifying item, argmax update, log2 on last.
// ----------------------------------------------------------------------------
module tea_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  tea_pkg::item_t                     q_word,
  input  logic [tea_pkg::TotalW-1:0]         test_total,
  input  logic [tea_pkg::TotalW-1:0]         control_total,
  input  logic                               normalize,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [tea_pkg::KeyW-1:0]           best_key,
  output logic signed [tea_pkg::ValueW-1:0]  best_value
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL1 = 7'b0000010, S_MUL2 = 7'b0000100,
    S_DIV  = 7'b0001000, S_UPD  = 7'b0010000, S_LOG  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                       state;
  tea_pkg::item_t               cur;
  logic [tea_pkg::NumW-1:0]     num;
  logic [tea_pkg::ProdW-1:0]    den;
  logic [tea_pkg::RatioW-1:0]   quo;
  logic [5:0]                   step;
  logic                         sat;
  logic [tea_pkg::RatioW-1:0]   best_ratio;
  logic [tea_pkg::KeyW-1:0]     best_index;
  logic                         have_best;
  logic [31:0]                  mant;
  logic [15:0]                  frac;
  logic [4:0]                   ipart;
  logic [63:0]                  sq;
  logic [tea_pkg::NumW+15:0]    dshift, dsub;
  logic [4:0]                   lead;

  assign q_pop = (state == S_IDLE) && q_valid;
  // mantissa stays below 2^32, so this is a 32x32 square
  assign sq = 64'(mant) * 64'(mant);
  // divisor shifted by up to 31 needs 103 bits, so 104 bits never wrap
  assign dshift = {32'd0, den} << step[4:0];
  assign dsub = {16'd0, num} - dshift;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) if (best_ratio[i]) lead = 5'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      have_best <= 1'b0;
      best_ratio <= '0;
      best_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_word;
          state <= q_word.qual ? S_MUL1 : (q_word.last ? S_LOG : S_IDLE);
        end
        S_MUL1: begin
          num <= {tea_pkg::ProdW'(cur.t) * tea_pkg::ProdW'(control_total), 16'd0};
          den <= tea_pkg::ProdW'(cur.c) * tea_pkg::ProdW'(test_total);
          state <= S_MUL2;
        end
        S_MUL2: begin
          // quotient would not fit 32 bits
          sat <= (den[tea_pkg::ProdW-1:56] == '0) && (num >= {den[55:0], 32'd0});
          quo <= '0;
          step <= 6'd31;
          state <= S_DIV;
        end
        S_DIV: begin
          if (sat) begin
            quo <= '1;
            state <= S_UPD;
          end else begin
            if ({16'd0, num} >= dshift) begin
              num <= dsub[tea_pkg::NumW-1:0];
              quo[step[4:0]] <= 1'b1;
            end
            if (step == 6'd0) state <= S_UPD;
            else step <= step - 1'b1;
          end
        end
        S_UPD: begin
          if (!have_best || quo > best_ratio) begin
            best_ratio <= quo;
            best_index <= cur.key;
            have_best <= 1'b1;
          end
          state <= cur.last ? S_LOG : S_IDLE;
        end
        S_LOG: begin
          // set up mantissa as Q1.31 with the leading one at bit 31
          mant <= best_ratio << (5'd31 - lead);
          ipart <= lead;
          frac <= '0;
          step <= 6'd15;
          state <= S_OUT;
          if (!(have_best && normalize && best_ratio != '0)) step <= 6'd62;
        end
        S_OUT: begin
          if (step <= 6'd15) begin
            if (sq[63]) begin
              frac[step[3:0]] <= 1'b1;
              mant <= sq[63:32];
            end else begin
              mant <= sq[62:31];
            end
            step <= (step == 6'd0) ? 6'd62 : step - 1'b1;
          end else if (!out_valid) begin
            out_valid <= 1'b1;
            found <= have_best;
            best_key <= have_best ? best_index : '0;
            if (!have_best) best_value <= '0;
            else if (!normalize) best_value <= {1'b0, best_ratio};
            else if (best_ratio == '0) best_value <= tea_pkg::LogFloor;
            else best_value <= ($signed({28'd0, ipart}) - 33'sd16) * 33'sd65536
                               + $signed({17'd0, frac});
          end else if (out_ready) begin
            out_valid <= 1'b0;
            have_best <= 1'b0;
            best_ratio <= '0;
            best_index <= '0;
            step <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/top_enrichment_argmax.sv -----
// ----------------------------------------------------------------------------
// top_enrichment_argmax: streaming argmax of k-mer enrichment
// A qualifying word holds the back end through pop, S_MUL1, S_MUL2, the
//   32 restoring divider steps and one update; a saturated one skips the steps.
// A non-qualifying word is only popped; a last word then goes through
//   S_LOG and S_OUT, squaring for log2 if normalizing, then offers the result.
// A new word is popped only in S_IDLE; a 4-word queue decouples input.
// Reset (rst, synchronous) clears registers, index, queue and best state.
// ----------------------------------------------------------------------------
module top_enrichment_argmax (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid,
  output logic                               ready,
  input  logic [tea_pkg::CountW-1:0]         test_hits,
  input  logic [tea_pkg::CountW-1:0]         control_hits,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [tea_pkg::KeyW-1:0]           best_key,
  output logic signed [tea_pkg::ValueW-1:0]  best_value,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [tea_pkg::TotalW-1:0]         cfg_data
);

  logic [tea_pkg::TotalW-1:0] test_total, control_total;
  logic                       normalize;
  logic                       q_valid, q_pop;
  tea_pkg::item_t             q_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      test_total <= '0;
      control_total <= '0;
      normalize <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tea_pkg::RegTestTotal:    test_total <= cfg_data;
        tea_pkg::RegControlTotal: control_total <= cfg_data;
        tea_pkg::RegNormalize:    normalize <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tea_front u_front (
    .clk, .rst, .valid, .ready, .test_hits, .control_hits, .last,
    .totals_ok(test_total != '0 && control_total != '0),
    .q_valid, .q_pop, .q_word
  );

  tea_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_word, .test_total, .control_total,
    .normalize, .out_valid, .out_ready, .found, .best_key, .best_value
  );

endmodule

// ----- hw/rtl/tea_checker.sv -----
// ----------------------------------------------------------------------------
// tea_checker: port-level checks
// Output handshake and result sanity.
// ----------------------------------------------------------------------------
module tea_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              found,
  input logic [tea_pkg::KeyW-1:0]          best_key,
  input logic signed [tea_pkg::ValueW-1:0] best_value
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_value))
    else $error("result dropped");
  a_nf: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_key == '0 && best_value == '0)
    else $error("empty result not zero");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("repeated result");

endmodule

bind top_enrichment_argmax tea_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .found, .best_key, .best_value
);

// ----- sim/tb_top_enrichment_argmax.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_enrichment_argmax: self-checking bench for the enrichment argmax
// Directed table of count words, then random passes under several idling
// phases; every result word is compared with a built-in predictor.
// ----------------------------------------------------------------------------
module tb_top_enrichment_argmax;

  localparam int  ClkHalf    = 4;
  localparam int  SettleCyc  = 80;    // back end latency plus log2 loop, padded
  localparam longint CycLimit = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [tea_pkg::CountW-1:0] test_hits = '0;
  logic [tea_pkg::CountW-1:0] control_hits = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [tea_pkg::KeyW-1:0] best_key;
  logic signed [tea_pkg::ValueW-1:0] best_value;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = tea_pkg::RegTestTotal;
  logic [tea_pkg::TotalW-1:0] cfg_data = '0;

  always #(ClkHalf) clk = ~clk;

  top_enrichment_argmax i_dut (.*);

  // expected result word
  typedef struct {
    logic                              found;
    logic [tea_pkg::KeyW-1:0]          key;
    logic signed [tea_pkg::ValueW-1:0] value;
  } argmax_t;

  argmax_t pending_q[$];
  int mismatches = 0;
  longint cycles = 0;

  // predictor state
  logic [tea_pkg::TotalW-1:0] p_ttot = '0, p_ctot = '0;
  logic                       p_norm = 1'b0;
  logic [tea_pkg::KeyW-1:0]   p_index = '0, p_best_idx = '0;
  logic [tea_pkg::RatioW-1:0] p_best = '0;
  logic                       p_have = 1'b0;

  // idling knobs (percent)
  int send_idle = 0, recv_stall = 0;
  logic hold_on = 1'b0;       // long receiver stall, timed in its own process

  // Q16.16 of (t*ctot)/(c*ttot), truncated, saturated
  function automatic logic [tea_pkg::RatioW-1:0] enrich_q16(
      logic [tea_pkg::CountW-1:0] t, logic [tea_pkg::CountW-1:0] c);
    logic [127:0] num, den, q;
    num = ({96'd0, t} * {88'd0, p_ctot}) << 16;
    den = {96'd0, c} * {88'd0, p_ttot};
    q = num / den;
    if (q > 128'hFFFF_FFFF) return '1;
    return q[31:0];
  endfunction

  // log2 of Q16.16 as signed Q16.16 in 33 bits, floored
  function automatic logic signed [tea_pkg::ValueW-1:0] log2_q7(
      logic [tea_pkg::RatioW-1:0] r);
    int msb;
    logic [63:0] m;
    logic [15:0] frac;
    if (r == 0) return tea_pkg::LogFloor;
    msb = 31;
    while (!r[msb]) msb--;
    m = {32'd0, r} << (31 - msb);
    frac = '0;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return tea_pkg::ValueW'(signed'((msb - 16) * 65536 + int'(frac)));
  endfunction

  // advance predictor by one accepted word
  task automatic predict_word(logic [tea_pkg::CountW-1:0] t,
                              logic [tea_pkg::CountW-1:0] c, logic l);
    logic [tea_pkg::RatioW-1:0] r;
    argmax_t e;
    if (t != 0 && c != 0 && p_ttot != 0 && p_ctot != 0) begin
      r = enrich_q16(t, c);
      if (!p_have || r > p_best) begin
        p_best = r;
        p_best_idx = p_index;
        p_have = 1'b1;
      end
    end
    p_index = p_index + 1'b1;
    if (l) begin
      e.found = p_have;
      e.key   = p_have ? p_best_idx : '0;
      e.value = !p_have ? '0 : p_norm ? log2_q7(p_best) : tea_pkg::ValueW'(p_best);
      pending_q.push_back(e);
      p_index = '0;
      p_best = '0;
      p_best_idx = '0;
      p_have = 1'b0;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [tea_pkg::TotalW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tea_pkg::RegTestTotal:    p_ttot = val;
      tea_pkg::RegControlTotal: p_ctot = val;
      default:                  p_norm = val[0];
    endcase
    @(posedge clk);
  endtask

  // drive one word; waits until ready is seen high after an edge, valid stays up for the next word
  task automatic send_word(logic [tea_pkg::CountW-1:0] t,
                           logic [tea_pkg::CountW-1:0] c, logic l);
    while ($urandom_range(99) < send_idle) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    test_hits <= t;
    control_hits <= c;
    last <= l;
    @(posedge clk);
    while (!ready) @(posedge clk);
    predict_word(t, c, l);
  endtask

  // idle until every result has come, plus the back end drain
  task automatic drain();
    valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  function automatic logic [tea_pkg::CountW-1:0] rand_count();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(16);
      3: return tea_pkg::CountW'(1) << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [tea_pkg::TotalW-1:0] rand_total();
    case ($urandom_range(4))
      0: return tea_pkg::TotalW'(1);
      1: return '1;
      2: return tea_pkg::TotalW'({$urandom, $urandom});
      default: return tea_pkg::TotalW'($urandom_range(100000, 1));
    endcase
  endfunction

  // result checker; receiver stalls at random, or holds off on request
  always @(posedge clk) begin
    argmax_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word key=%0d", best_key);
      end else begin
        e = pending_q.pop_front();
        if (found !== e.found || best_key !== e.key || best_value !== e.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0b/%0d/%0d got %0b/%0d/%0d", e.found, e.key,
                     e.value, found, best_key, best_value);
        end
      end
    end
    if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (cycles > CycLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // directed rows: t, c, last, check-at-a-glance flag and expected word
  typedef struct {
    logic [tea_pkg::CountW-1:0] t, c;
    logic                       l;
    logic                       typed;
    argmax_t                    want;
  } row_t;

  row_t rows[$];

  task automatic add_row(logic [tea_pkg::CountW-1:0] t, logic [tea_pkg::CountW-1:0] c,
                         logic l, logic typed = 1'b0, logic f = 1'b0,
                         logic [tea_pkg::KeyW-1:0] k = '0,
                         logic signed [tea_pkg::ValueW-1:0] v = '0);
    row_t r;
    r.t = t; r.c = c; r.l = l; r.typed = typed;
    r.want.found = f; r.want.key = k; r.want.value = v;
    rows.push_back(r);
  endtask

  // walk the table; for typed rows the predicted word is held against the written-in word
  task automatic run_rows();
    argmax_t got;
    foreach (rows[i]) begin
      send_word(rows[i].t, rows[i].c, rows[i].l);
      if (rows[i].typed) begin
        got = pending_q[$];
        if (got.found !== rows[i].want.found || got.key !== rows[i].want.key ||
            got.value !== rows[i].want.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: exp %0b/%0d/%0d got %0b/%0d/%0d", i,
                     rows[i].want.found, rows[i].want.key, rows[i].want.value,
                     got.found, got.key, got.value);
        end
      end
    end
  endtask

  initial begin
    int n_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // totals zero after reset: nothing qualifies
    add_row(5, 3, 1'b0);
    add_row('1, '1, 1'b1, 1'b1, 1'b0, '0, '0);
    run_rows();
    drain();

    // equal totals: ratio is t/c; extremes, zeros, ties
    write_reg(tea_pkg::RegTestTotal, 40'd1);
    write_reg(tea_pkg::RegControlTotal, 40'd1);
    write_reg(tea_pkg::RegNormalize, 40'd0);
    rows.delete();
    add_row(0, 7, 1'b0);
    add_row(7, 0, 1'b0);
    add_row(1, 1, 1'b0);                     // ratio 1.0 at key 2
    add_row(2, 2, 1'b0);                     // tie, earliest wins
    add_row(0, 0, 1'b1, 1'b1, 1'b1, 20'd2, 33'sh1_0000);
    add_row(0, 0, 1'b1, 1'b1, 1'b0, '0, '0); // nothing qualified
    add_row('1, 1, 1'b1, 1'b1, 1'b1, '0, 33'hFFFF_FFFF); // saturation
    add_row(1, '1, 1'b1, 1'b1, 1'b1, '0, '0);            // tiny ratio floors to 0
    run_rows();
    drain();

    // log2 output, including zero ratio and extremes
    write_reg(tea_pkg::RegNormalize, 40'd1);
    rows.delete();
    add_row(1, '1, 1'b1);
    add_row(1, 1, 1'b1);
    add_row('1, 1, 1'b1);
    add_row(3, 2, 1'b0);
    add_row(5, 7, 1'b1);
    run_rows();
    drain();
    write_reg(tea_pkg::RegTestTotal, '1);
    write_reg(tea_pkg::RegControlTotal, '1);
    send_word('1, 1, 1'b0);
    send_word(1, '1, 1'b1);
    drain();

    // random passes, four idling phases
    n_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 8) : 0;
      recv_stall = (ph == 2) ? 84 : (ph == 3 ? 8 : 0);
      write_reg(tea_pkg::RegTestTotal, rand_total());
      write_reg(tea_pkg::RegControlTotal, rand_total());
      write_reg(tea_pkg::RegNormalize, tea_pkg::TotalW'($urandom_range(1)));
      if (ph == 0) begin
        // block fills up while words keep coming
        fork
          begin
            hold_on <= 1'b1;
            repeat (2000) @(posedge clk);
            hold_on <= 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 350; k++) begin
        send_word(rand_count(), rand_count(), $urandom_range(11) == 0);
        if (k == 175) begin
          // sender pauses until everything is out
          valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      send_word(rand_count(), rand_count(), 1'b1);
      drain();
      n_items += 351;
    end

    // a pass with zero test total among nonzero counts
    write_reg(tea_pkg::RegTestTotal, 40'd0);
    send_word(9, 9, 1'b0);
    send_word(4, 1, 1'b1);
    drain();

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tea_pkg.sv
hw/rtl/tea_front.sv
hw/rtl/tea_back.sv
hw/rtl/top_enrichment_argmax.sv
hw/rtl/tea_checker.sv
sim/tb_top_enrichment_argmax.sv
